// ----- rtl/core/rps_pkg.sv -----
// shared constants for the random permutation shuffler
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

   // field widths
   localparam int RANDOM_W   = 15;
   localparam int POS_W      = 6;
   localparam int COUNT_W    = 7;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // defaults
   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 7'd50;

endpackage

`default_nettype wire

// ----- rtl/core/random_permutation_shuffler_top.sv -----
// top level of the fisher-yates permutation shuffler
// sequence: a beat starts a serial remainder of the random word, then read, read, write,
//   write and the output register; a new random word is taken only in the idle state
// a step's result must be issued before the next word is accepted, and the final step of a
//   permutation then also issues the tail result from its own state; result stalls hold the flow
// reset: step index 0, touched marks cleared, entry count 50; memory left as is
`timescale 1ns / 1ps
`default_nettype none

module random_permutation_shuffler_top #(
   parameter int MAX_ENTRIES = rps_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire                              clock,
   input  wire                              reset,
   // request: [14:0] random_word
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [rps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response: [5:0] position, [11:6] entry_value
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // response: [0] last
   output logic                             rsp_tlast,
   // entry_count register write
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [rps_pkg::COUNT_W-1:0]      csr_data
);
   import rps_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_J,
      ST_CAPTURE,
      ST_WRITE_J,
      ST_EMIT,
      ST_TAIL
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IW-1:0]      step_ff, step_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      j_ff, j_in;
   logic [IW-1:0]      vi_ff, vi_in;
   logic [IW-1:0]      vj_ff, vj_in;
   logic               last_step_ff, last_step_in;
   logic [MAX_ENTRIES-1:0] touched_ff, touched_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]   rsp_val_ff, rsp_val_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory and divider hookup
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [IW-1:0]      ram_wr_data;
   logic               ram_rd_en;
   logic [IW-1:0]      ram_rd_addr;
   logic [IW-1:0]      ram_rd_data;
   logic               div_start;
   logic [CW-1:0]      div_divisor;
   logic               div_done;
   logic [CW-1:0]      div_rem;

   // step setup from the current register value
   logic [NW-1:0]      count_w;
   logic [CW-1:0]      n_new;
   logic               abandon;
   logic [IW-1:0]      i_new;
   logic               slot_free;
   logic               req_beat;
   logic [IW-1:0]      tail_addr;

   assign count_w   = NW'(count_ff);
   assign n_new     = (count_w < NW'(2)) ? CW'(2) :
                      (count_w > NW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_w);
   assign abandon   = CW'(step_ff) > (n_new - CW'(2));
   assign i_new     = abandon ? '0 : step_ff;
   assign req_beat  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign tail_addr = IW'(n_ff - CW'(1));

   assign div_start   = req_beat;
   assign div_divisor = n_new - CW'(i_new);

   rps_serial_mod #(
      .CW (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[RANDOM_W-1:0]),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   rps_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // step sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      last_step_in = last_step_ff;
      touched_in   = touched_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = i_ff;
      ram_wr_data  = vj_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = i_ff;

      if (csr_valid) begin
         count_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               n_in         = n_new;
               i_in         = i_new;
               last_step_in = (CW'(i_new) == (n_new - CW'(2)));
               if (abandon) begin
                  touched_in = '0;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               j_in      = IW'(CW'(i_ff) + div_rem);
               ram_rd_en = 1'b1;
               state_in  = ST_READ_J;
            end
         end
         ST_READ_J: begin
            // entry i is on the read port, ask for entry j
            vi_in       = touched_ff[i_ff] ? ram_rd_data : i_ff;
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff;
            state_in    = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            // entry j arrives; it goes to position i
            vj_in       = touched_ff[j_ff] ? ram_rd_data : j_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = touched_ff[j_ff] ? ram_rd_data : j_ff;
            touched_in[i_ff] = 1'b1;
            state_in    = ST_WRITE_J;
         end
         ST_WRITE_J: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = vi_ff;
            touched_in[j_ff] = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(i_ff);
               rsp_val_in   = POS_W'(vj_ff);
               rsp_last_in  = 1'b0;
               if (last_step_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = tail_addr;
                  state_in    = ST_TAIL;
               end else begin
                  step_in  = i_ff + IW'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            // final position, then start the next permutation from identity
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(tail_addr);
               rsp_val_in   = POS_W'(touched_ff[tail_addr] ? ram_rd_data : tail_addr);
               rsp_last_in  = 1'b1;
               touched_in   = '0;
               step_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= ENTRY_COUNT_RESET;
         step_ff      <= '0;
         touched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         touched_ff   <= touched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      vi_ff        <= vi_in;
      vj_ff        <= vj_in;
      last_step_ff <= last_step_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_val_ff, rsp_pos_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rps_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rps_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rps_serial_mod.sv -----
// bit-serial restoring remainder of the random word by a variable divisor
`timescale 1ns / 1ps
`default_nettype none

module rps_serial_mod #(
   parameter int CW = 7
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [rps_pkg::RANDOM_W-1:0]   dividend,
   input  wire  [CW-1:0]                  divisor,
   output logic                           done,
   output logic [CW-1:0]                  remainder
);
   import rps_pkg::*;

   localparam int CNT_W = $clog2(RANDOM_W + 1);

   logic [RANDOM_W-1:0] word_ff, word_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       div_ff, div_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW:0]         trial;

   // one quotient bit per cycle, msb of the word first
   always_comb begin
      word_in = word_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, word_ff[RANDOM_W-1]};
      if (start) begin
         word_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(RANDOM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = CW'(trial);
         end
         word_in = {word_ff[RANDOM_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      word_ff <= word_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- tb/sv/rps_checker.sv -----
// scoreboard for the permutation shuffler: predicts placements and checks result beats
`timescale 1ns / 1ps

module rps_checker #(
   parameter int MAX_ENTRIES = rps_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire  [rps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [rps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              rsp_tlast,
   input  wire                              csr_valid,
   input  wire                              csr_ready,
   input  wire  [rps_pkg::COUNT_W-1:0]      csr_data,
   output int                               fail_count,
   output int                               pending_results,
   output int                               placements_checked,
   output int                               perms_completed
);

   typedef struct packed {
      logic [rps_pkg::POS_W-1:0] position;
      logic [rps_pkg::POS_W-1:0] entry_value;
      logic                      last;
   } placement_type;

   placement_type              expected_placements[$];
   logic [rps_pkg::COUNT_W-1:0] entry_count;
   int                         step_index;
   logic [rps_pkg::POS_W-1:0]  perm_store [MAX_ENTRIES];
   bit                         touched [MAX_ENTRIES];
   int                         failures;
   int                         checked;
   int                         perms;

   initial begin
      failures           = 0;
      checked            = 0;
      perms              = 0;
   end

   // an untouched entry holds its own index
   function automatic logic [rps_pkg::POS_W-1:0] entry_at(input int k);
      logic [rps_pkg::POS_W-1:0] own;
      own = k[rps_pkg::POS_W-1:0];
      if (k >= MAX_ENTRIES) return '0;
      return touched[k] ? perm_store[k] : own;
   endfunction

   task automatic place_entry(input int k, input logic [rps_pkg::POS_W-1:0] v);
      if (k < MAX_ENTRIES) begin
         perm_store[k] = v;
         touched[k]    = 1'b1;
      end
   endtask

   task automatic clear_touched();
      foreach (touched[k]) touched[k] = 1'b0;
   endtask

   // one fisher-yates step: swap i with a random j at or above i, then emit i
   task automatic shuffle_step(input logic [rps_pkg::RANDOM_W-1:0] word);
      int                        n;
      int                        i;
      int                        j;
      logic [rps_pkg::POS_W-1:0] vi;
      logic [rps_pkg::POS_W-1:0] vj;
      placement_type             p;
      n = entry_count;
      if (n < 2) n = 2;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      // count shrank below the current step: start a fresh permutation
      if (step_index > n - 2) begin
         clear_touched();
         step_index = 0;
      end
      i  = step_index;
      j  = int'(word) % (n - i) + i;
      vi = entry_at(i);
      vj = entry_at(j);
      place_entry(i, vj);
      place_entry(j, vi);
      p.position    = i[rps_pkg::POS_W-1:0];
      p.entry_value = vj;
      p.last        = 1'b0;
      expected_placements.push_back(p);
      if (i == n - 2) begin
         // the tail entry is final too
         p.position    = 6'(n - 1);
         p.entry_value = entry_at(n - 1);
         p.last        = 1'b1;
         expected_placements.push_back(p);
         clear_touched();
         step_index = 0;
      end else begin
         step_index = i + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      failures++;
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         entry_count = rps_pkg::ENTRY_COUNT_RESET;
         step_index  = 0;
         clear_touched();
         expected_placements.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_placements.size() == 0) begin
               report_mismatch("result beat with nothing expected, position",
                               int'(rsp_tdata[5:0]), -1);
            end else begin
               want = expected_placements.pop_front();
               if (rsp_tdata[5:0] !== want.position)
                  report_mismatch("position", int'(rsp_tdata[5:0]), int'(want.position));
               if (rsp_tdata[11:6] !== want.entry_value)
                  report_mismatch("entry_value", int'(rsp_tdata[11:6]),
                                  int'(want.entry_value));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", int'(rsp_tlast), int'(want.last));
               checked++;
               if (want.last) perms++;
            end
         end
         if (csr_valid && csr_ready) entry_count = csr_data;
         if (req_tvalid && req_tready) shuffle_step(req_tdata[rps_pkg::RANDOM_W-1:0]);
      end
      fail_count         <= failures;
      pending_results    <= expected_placements.size();
      placements_checked <= checked;
      perms_completed    <= perms;
   end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the permutation shuffler: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int RANDOM_WORDS = 400;
   localparam int HOLD_CYCLES  = 600;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   wire                             req_tready;
   logic [rps_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   wire                             rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   wire  [rps_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   wire                             rsp_tlast;
   logic                            csr_valid  = 1'b0;
   wire                             csr_ready;
   logic [rps_pkg::COUNT_W-1:0]     csr_data   = '0;

   int mismatches;
   int pending_count;
   int placements_checked;
   int perms_completed;
   int words_sent     = 0;
   int count_settings = 0;
   int cycle_count    = 0;
   bit no_idle        = 1'b0;
   bit hold_rsp       = 1'b0;

   random_permutation_shuffler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   rps_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .fail_count         (mismatches),
      .pending_results    (pending_count),
      .placements_checked (placements_checked),
      .perms_completed    (perms_completed)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d placements still expected",
               cycle_count, pending_count);
      $display("Test completed with failures");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit holding;
      bit hold_taken;
      hold_taken = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         holding = hold_rsp && !hold_taken;
         if (holding) begin
            stall      = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         else if (no_idle) stall = 0;
         else stall = $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one random word beat, with an optional gap ahead of it
   task automatic send_word(input logic [rps_pkg::RANDOM_W-1:0] word);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, word};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // stop offering and let every expected placement arrive
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [rps_pkg::COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_settings++;
   endtask

   // stimulus and verdict
   initial begin
      int  random_words;
      int  items;
      int  eff;
      bit  hold_done;
      logic [rps_pkg::COUNT_W-1:0] count_value;
      random_words = 0;
      hold_done    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset count, word extremes
      send_word(15'h0000);
      send_word(15'h7fff);
      send_word(15'h5555);
      // two-entry permutation, each word gives two placements
      wait_drained();
      write_entry_count(7'd2);
      send_word(15'h0000);
      send_word(15'h7fff);
      // counts below range saturate to two
      wait_drained();
      write_entry_count(7'd0);
      send_word(15'h1234);
      wait_drained();
      write_entry_count(7'd1);
      send_word(15'h7fff);
      // counts above range saturate to the maximum
      wait_drained();
      write_entry_count(7'd127);
      send_word(15'h2aaa);
      send_word(15'h0001);
      send_word(15'h7ffe);
      wait_drained();
      write_entry_count(7'd65);
      send_word(15'h4000);
      wait_drained();
      write_entry_count(7'd64);
      repeat (6) send_word(15'($urandom_range(0, 32767)));
      // shrink the count below the current step: permutation is abandoned
      wait_drained();
      write_entry_count(7'd4);
      send_word(15'h0003);
      // three entries run to completion
      wait_drained();
      write_entry_count(7'd3);
      send_word(15'h7fff);
      send_word(15'h0000);

      // random phases: full permutations plus partial ones cut by a count change
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0: count_value = 7'($urandom_range(0, 127));
            1: begin
               case ($urandom_range(0, 5))
                  0: count_value = 7'd0;
                  1: count_value = 7'd1;
                  2: count_value = 7'd2;
                  3: count_value = 7'd64;
                  4: count_value = 7'd65;
                  default: count_value = 7'd127;
               endcase
            end
            2: count_value = 7'd2;
            default: count_value = 7'($urandom_range(2, 16));
         endcase
         eff = (count_value < 2) ? 2 : (count_value > 64) ? 64 : count_value;
         items = (eff - 1) * $urandom_range(1, 2) + $urandom_range(0, 3);
         if (items > RANDOM_WORDS - random_words) items = RANDOM_WORDS - random_words;
         wait_drained();
         write_entry_count(count_value);
         if (!hold_done && random_words >= 150) begin
            // results held back while words keep coming, so the block backs up
            hold_done = 1'b1;
            no_idle   = 1'b1;
            hold_rsp  = 1'b1;
            if (items < 40) items = 40;
         end else begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         repeat (items) begin
            send_word(15'($urandom_range(0, 32767)));
            random_words++;
         end
      end
      no_idle = 1'b0;
      wait_drained();

      $display("sent %0d random words across %0d entry count writes, counts 0 to 127",
               words_sent, count_settings);
      $display("checked %0d placements, %0d permutations ran to their final entry",
               placements_checked, perms_completed);
      if (mismatches == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
